[design/hgsd_pkg.sv]
// Shared types and constants for the Hershey glyph stroke decoder.
// No dependencies; every other design file refers to this package by scope.
package hgsd_pkg;

  localparam int CHAR_BIAS    = 82;   // 'R': character code of offset zero
  localparam int LIFT_CHAR_X  = 32;   // ' ': x character code of the pen-lift pair
  localparam int QUEUE_DEPTH  = 4;

  localparam int CHAR_W   = 7;
  localparam int ORIGIN_W = 9;
  localparam int OFF_W    = 8;
  localparam int POS_W    = 11;
  localparam int WIDTH_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 1'b0,
    REG_ORIGIN_Y = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_MOVE = 2'd0,
    CMD_DRAW = 2'd1,
    CMD_DONE = 2'd2
  } cmd_t;

  // One classified item, as handed from the front to the back.
  typedef struct packed {
    logic                    has_stroke;
    cmd_t                    stroke_cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    has_done;
    logic [WIDTH_W-1:0]      width;
  } entry_t;

endpackage

[design/hgsd_if.sv]
// Valid/ready channel interfaces for the stroke decoder's input and results.
// Depends on hgsd_pkg for field widths and the command type.
interface hgsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [hgsd_pkg::CHAR_W-1:0]   char_x;
  logic [hgsd_pkg::CHAR_W-1:0]   char_y;
  logic                          is_bounds;
  logic                          is_final;

  modport source (output valid, char_x, char_y, is_bounds, is_final, input ready);
  modport sink   (input valid, char_x, char_y, is_bounds, is_final, output ready);
endinterface

interface hgsd_out_if;
  logic                                 valid;
  logic                                 ready;
  hgsd_pkg::cmd_t                       command;
  logic signed [hgsd_pkg::POS_W-1:0]    pos_x;
  logic signed [hgsd_pkg::POS_W-1:0]    pos_y;
  logic [hgsd_pkg::WIDTH_W-1:0]         glyph_width;
  logic                                 run_end;

  modport source (output valid, command, pos_x, pos_y, glyph_width, run_end, input ready);
  modport sink   (input valid, command, pos_x, pos_y, glyph_width, run_end, output ready);
endinterface

[design/hgsd_front.sv]
// Front end: accepts stroke pairs, tracks pen and bounding box, and classifies
// each pair into a queue entry. Depends on hgsd_pkg and hgsd_if.
module hgsd_front (
  input  logic                clk,
  input  logic                rst_n,
  hgsd_in_if.sink             in_chan,
  input  logic                cfg_we,
  input  logic [hgsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hgsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                q_full,
  output logic                q_push,
  output hgsd_pkg::entry_t    q_entry
);

  logic [hgsd_pkg::ORIGIN_W-1:0] origin_x_r, origin_y_r;
  logic                          pen_lifted_r, pen_lifted_nxt;
  logic signed [hgsd_pkg::OFF_W-1:0] xmin_r, xmax_r, ymin_r, ymax_r;
  logic signed [hgsd_pkg::OFF_W-1:0] xmin_nxt, xmax_nxt, ymin_nxt, ymax_nxt;
  logic signed [hgsd_pkg::OFF_W-1:0] x_off, y_off;
  logic                          accept, is_lift, has_stroke;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  assign x_off = {1'b0, in_chan.char_x} - hgsd_pkg::OFF_W'(hgsd_pkg::CHAR_BIAS);
  assign y_off = {1'b0, in_chan.char_y} - hgsd_pkg::OFF_W'(hgsd_pkg::CHAR_BIAS);

  assign is_lift = (in_chan.char_x == hgsd_pkg::CHAR_W'(hgsd_pkg::LIFT_CHAR_X)) &&
                   (in_chan.char_y == hgsd_pkg::CHAR_W'(hgsd_pkg::CHAR_BIAS));
  assign has_stroke = !in_chan.is_bounds && !is_lift;

  always_comb begin
    pen_lifted_nxt = pen_lifted_r;
    xmin_nxt = xmin_r;
    xmax_nxt = xmax_r;
    ymin_nxt = ymin_r;
    ymax_nxt = ymax_r;
    if (in_chan.is_bounds) begin
      pen_lifted_nxt = 1'b1;
      xmin_nxt = '0;
      xmax_nxt = '0;
      ymin_nxt = '0;
      ymax_nxt = '0;
    end else if (is_lift) begin
      pen_lifted_nxt = 1'b1;
    end else begin
      pen_lifted_nxt = 1'b0;
      if (x_off < xmin_r) xmin_nxt = x_off;
      if (x_off > xmax_r) xmax_nxt = x_off;
      if (y_off < ymin_r) ymin_nxt = y_off;
      if (y_off > ymax_r) ymax_nxt = y_off;
    end
  end

  always_comb begin
    q_entry.has_stroke = has_stroke;
    q_entry.stroke_cmd = pen_lifted_r ? hgsd_pkg::CMD_MOVE : hgsd_pkg::CMD_DRAW;
    q_entry.pos_x = $signed({2'b00, origin_x_r}) +
                    {{(hgsd_pkg::POS_W-hgsd_pkg::OFF_W){x_off[hgsd_pkg::OFF_W-1]}}, x_off};
    q_entry.pos_y = $signed({2'b00, origin_y_r}) +
                    {{(hgsd_pkg::POS_W-hgsd_pkg::OFF_W){y_off[hgsd_pkg::OFF_W-1]}}, y_off};
    q_entry.has_done = in_chan.is_final;
    q_entry.width    = hgsd_pkg::WIDTH_W'(xmax_nxt - xmin_nxt);
  end

  // Drop pairs that cause no result.
  assign q_push = accept && (has_stroke || in_chan.is_final);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      pen_lifted_r <= 1'b1;
      xmin_r <= '0;
      xmax_r <= '0;
      ymin_r <= '0;
      ymax_r <= '0;
    end else begin
      if (cfg_we) begin
        case (hgsd_pkg::cfg_reg_t'(cfg_index))
          hgsd_pkg::REG_ORIGIN_X: origin_x_r <= cfg_wdata;
          hgsd_pkg::REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        pen_lifted_r <= pen_lifted_nxt;
        xmin_r <= xmin_nxt;
        xmax_r <= xmax_nxt;
        ymin_r <= ymin_nxt;
        ymax_r <= ymax_nxt;
      end
    end
  end

  bounds_clear_a: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.is_bounds |=> pen_lifted_r && xmin_r == 0 && xmax_r == 0)
    else $error("bound pair did not reset pen and box");

  box_order_a: assert property (@(posedge clk) disable iff (!rst_n)
    xmin_r <= xmax_r && ymin_r <= ymax_r)
    else $error("bounding box inverted");

endmodule

[design/hgsd_queue.sv]
// Short FIFO of classified entries between front and back.
// Depends on hgsd_pkg for the entry type.
module hgsd_queue #(
  parameter int DEPTH = hgsd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hgsd_pkg::entry_t push_entry,
  input  logic             pop,
  output hgsd_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hgsd_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  no_overflow_a: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");

  no_underflow_a: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");

  count_track_a: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

[design/hgsd_back.sv]
// Back end: expands each queue entry into one or two results and holds them
// in an output register. Depends on hgsd_pkg and hgsd_if.
module hgsd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  hgsd_pkg::entry_t head,
  input  logic             q_empty,
  output logic             q_pop,
  hgsd_out_if.source       out_chan
);

  logic                              out_valid_r, out_valid_nxt;
  hgsd_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic signed [hgsd_pkg::POS_W-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [hgsd_pkg::WIDTH_W-1:0]      width_r, width_nxt;
  logic                              run_end_r, run_end_nxt;
  logic                              stroke_sent_r, stroke_sent_nxt;
  logic                              load_ok;

  assign load_ok = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    cmd_nxt         = cmd_r;
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    width_nxt       = width_r;
    run_end_nxt     = run_end_r;
    stroke_sent_nxt = stroke_sent_r;
    q_pop           = 1'b0;
    if (load_ok && !q_empty) begin
      out_valid_nxt = 1'b1;
      if (head.has_stroke && !stroke_sent_r) begin
        cmd_nxt     = head.stroke_cmd;
        pos_x_nxt   = head.pos_x;
        pos_y_nxt   = head.pos_y;
        width_nxt   = '0;
        run_end_nxt = !head.has_done;
        // Hold the entry when its done result still follows.
        stroke_sent_nxt = head.has_done;
        q_pop           = !head.has_done;
      end else begin
        cmd_nxt         = hgsd_pkg::CMD_DONE;
        pos_x_nxt       = '0;
        pos_y_nxt       = '0;
        width_nxt       = head.width;
        run_end_nxt     = 1'b1;
        stroke_sent_nxt = 1'b0;
        q_pop           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      stroke_sent_r <= 1'b0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      stroke_sent_r <= stroke_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    pos_x_r   <= pos_x_nxt;
    pos_y_r   <= pos_y_nxt;
    width_r   <= width_nxt;
    run_end_r <= run_end_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.command     = cmd_r;
  assign out_chan.pos_x       = pos_x_r;
  assign out_chan.pos_y       = pos_y_r;
  assign out_chan.glyph_width = width_r;
  assign out_chan.run_end     = run_end_r;

  half_sent_a: assert property (@(posedge clk) disable iff (!rst_n)
    stroke_sent_r |-> !q_empty && head.has_stroke && head.has_done)
    else $error("split entry lost from queue head");

  done_ends_run_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !run_end_r |-> cmd_r != hgsd_pkg::CMD_DONE)
    else $error("done result not marked as run end");

  half_sent_done_next_a: assert property (@(posedge clk) disable iff (!rst_n)
    stroke_sent_r && out_valid_r |-> !run_end_r)
    else $error("stroke before pending done marked as run end");

endmodule

[design/hershey_glyph_stroke_decoder_core.sv]
// Top level of the Hershey glyph stroke decoder.
// Depends on hgsd_pkg, hgsd_if, hgsd_front, hgsd_queue and hgsd_back.
//
// Usage:
//   in_chan  takes one stroke character pair per transfer (valid/ready),
//            with flags for the glyph's leading bound pair and its last pair.
//   out_chan gives move/draw results at origin plus offset and a done result
//            with the glyph width; run_end marks the last result of a pair.
//   cfg_we/cfg_index/cfg_wdata write origin_x (index 0) and origin_y
//            (index 1); write only while no pair is in flight.
// Order: a pair's entry is written into the queue and then loaded into the output
//   register, which offers the first result; the done result of a pair that also
//   draws follows from the same entry once the stroke result has been taken.
// Throughput: one pair per cycle while the queue is not full; a pair giving
//   both a stroke and a done result holds the output register for both. The
//   entry queue (QUEUE_DEPTH deep) absorbs short runs of such pairs; a
//   sustained run of them fills the queue, and in_chan.ready then drops.
// Reset: pen up, bounding box and origins cleared, queue and output empty.
// Stall: when out_chan.ready is low the output register holds its result;
//   the queue fills and in_chan.ready drops once it is full.
module hershey_glyph_stroke_decoder_core #(
  parameter int QUEUE_DEPTH = hgsd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hgsd_in_if.sink                         in_chan,
  hgsd_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [hgsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hgsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  hgsd_pkg::entry_t push_entry, head;
  logic             q_push, q_pop, q_empty, q_full;

  hgsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  hgsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  hgsd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
